// File: hw/rtl/quoted_block_tokenizer_assert.svh
// Assertion macros for the quoted block tokenizer.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef QUOTED_BLOCK_TOKENIZER_ASSERT_SVH
`define QUOTED_BLOCK_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qbt: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define QBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qbt: next-cycle check failed");

`endif

// File: hw/rtl/qbt_pkg.sv
// Types, codes and step helpers for the quoted block tokenizer.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package qbt_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_BLOCK  = 2'd2,
    MODE_CLOSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BLOCK_OPEN  = 2'd1,
    ST_STRING_OPEN = 2'd2,
    ST_TOO_LONG    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_DELIM_LO  = 3'd0,
    REG_DELIM_HI  = 3'd1,
    REG_ESCAPE    = 3'd2,
    REG_QUOTE_A   = 3'd3,
    REG_QUOTE_B   = 3'd4,
    REG_BLK_OPEN  = 3'd5,
    REG_BLK_CLOSE = 3'd6,
    REG_MAX_LEN   = 3'd7
  } cfg_idx_t;

  localparam int unsigned CharW  = 8;
  localparam int unsigned LenW   = 13;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MaxRes = 3;

  localparam logic [CharW-1:0] EscapeRst   = 8'd92;
  localparam logic [CharW-1:0] QuoteARst   = 8'd34;
  localparam logic [CharW-1:0] QuoteBRst   = 8'd39;
  localparam logic [CharW-1:0] BlkOpenRst  = 8'd123;
  localparam logic [CharW-1:0] BlkCloseRst = 8'd125;
  localparam logic [LenW-1:0]  MaxLenRst   = 13'd256;

  typedef struct packed {
    kind_t             kind;
    logic [CharW-1:0]  value;
    logic [LenW-1:0]   token_length;
    status_t           status;
  } tok_res_t;

  typedef tok_res_t [MaxRes-1:0] res_vec_t;

  // Append one result to the group; a full group drops it.
  function automatic void put_res(inout res_vec_t rv, inout logic [1:0] n,
                                  input kind_t k, input logic [CharW-1:0] v,
                                  input logic [LenW-1:0] len, input status_t s);
    if (n != 2'd3) begin
      rv[n].kind         = k;
      rv[n].value        = v;
      rv[n].token_length = len;
      rv[n].status       = s;
      n = n + 2'd1;
    end
  endfunction

  // Add one character to the token, or flag the length error.
  function automatic logic text_char(inout res_vec_t rv, inout logic [1:0] n,
                                     inout logic [LenW-1:0] cnt, inout logic err,
                                     input logic [LenW-1:0] max_len,
                                     input logic [CharW-1:0] c);
    logic ok;
    if ({1'b0, cnt} + 14'd1 >= {1'b0, max_len}) begin
      put_res(rv, n, KIND_ERR, '0, '0, ST_TOO_LONG);
      err = 1'b1;
      ok  = 1'b0;
    end else begin
      cnt = cnt + 13'd1;
      put_res(rv, n, KIND_CHAR, c, '0, ST_OK);
      ok  = 1'b1;
    end
    return ok;
  endfunction

  // Close the token with its delimiter and length.
  function automatic void finish_tok(inout res_vec_t rv, inout logic [1:0] n,
                                     inout logic [LenW-1:0] cnt,
                                     input logic [CharW-1:0] delim);
    put_res(rv, n, KIND_END, delim, cnt, ST_OK);
    cnt = '0;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qbt_in_if.sv
// Character input channel of the quoted block tokenizer.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface qbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_expr;

  modport source (output valid, output char_in, output end_of_expr, input ready);
  modport sink   (input valid, input char_in, input end_of_expr, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qbt_out_if.sv
// Result channel of the quoted block tokenizer.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface qbt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic [12:0] token_length;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output kind, output value, output token_length,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input value, input token_length,
                  input status, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/quoted_block_tokenizer.sv
// Quoted block tokenizer: an accepted character's first result beat is offered on the
// next cycle. A character with several results holds the input until its last beat is
// taken (the three-slot result buffer drains one beat per cycle while out_if.ready is
// high); one-result and no-result characters stream at one per cycle while it is high.
// Synchronous active-low reset clears scan state and the result buffer and loads the
// register defaults. Uses qbt_pkg, qbt_in_if, qbt_out_if and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "quoted_block_tokenizer_assert.svh"

module quoted_block_tokenizer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  qbt_in_if.sink                             in_if,
  qbt_out_if.source                          out_if,
  input  wire logic                          cfg_we,
  input  wire logic [qbt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [qbt_pkg::CfgW-1:0]      cfg_wdata
);

  // configuration
  logic [63:0]                    delim_lo_r, delim_hi_r;
  logic [qbt_pkg::CharW-1:0]      esc_char_r, quote_a_r, quote_b_r;
  logic [qbt_pkg::CharW-1:0]      blk_open_r, blk_close_r;
  logic [qbt_pkg::LenW-1:0]       max_len_r;

  // scan state
  qbt_pkg::mode_t                 mode_r, mode_nxt;
  logic                           esc_r, esc_nxt;
  logic [qbt_pkg::CharW-1:0]      oq_r, oq_nxt;
  logic [qbt_pkg::LenW-1:0]       cnt_r, cnt_nxt;
  logic                           err_r, err_nxt;

  // result buffer
  qbt_pkg::res_vec_t              slot_r;
  logic [1:0]                     res_cnt_r;

  qbt_pkg::res_vec_t              step_rv;
  logic [1:0]                     step_n;
  logic                           go, ok;
  logic [127:0]                   dmap;
  logic [qbt_pkg::CharW-1:0]      c;
  logic                           c_dl, c_esc, c_term;
  logic                           in_fire, out_fire;

  assign dmap     = {delim_hi_r, delim_lo_r};
  assign c        = in_if.char_in;
  assign c_dl     = !c[7] && dmap[c[6:0]];
  assign c_esc    = (esc_char_r != '0) && (c == esc_char_r);
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready = (res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && out_if.ready);
  assign in_fire  = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_lo_r  <= '0;
      delim_hi_r  <= '0;
      esc_char_r  <= qbt_pkg::EscapeRst;
      quote_a_r   <= qbt_pkg::QuoteARst;
      quote_b_r   <= qbt_pkg::QuoteBRst;
      blk_open_r  <= qbt_pkg::BlkOpenRst;
      blk_close_r <= qbt_pkg::BlkCloseRst;
      max_len_r   <= qbt_pkg::MaxLenRst;
    end else if (cfg_we) begin
      unique case (qbt_pkg::cfg_idx_t'(cfg_index))
        qbt_pkg::REG_DELIM_LO:  delim_lo_r  <= cfg_wdata;
        qbt_pkg::REG_DELIM_HI:  delim_hi_r  <= cfg_wdata;
        qbt_pkg::REG_ESCAPE:    esc_char_r  <= cfg_wdata[7:0];
        qbt_pkg::REG_QUOTE_A:   quote_a_r   <= cfg_wdata[7:0];
        qbt_pkg::REG_QUOTE_B:   quote_b_r   <= cfg_wdata[7:0];
        qbt_pkg::REG_BLK_OPEN:  blk_open_r  <= cfg_wdata[7:0];
        qbt_pkg::REG_BLK_CLOSE: blk_close_r <= cfg_wdata[7:0];
        qbt_pkg::REG_MAX_LEN:   max_len_r   <= cfg_wdata[12:0];
      endcase
    end
  end

  // One character: all results and the next scan state in a single pass.
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    oq_nxt   = oq_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    step_rv  = '0;
    step_n   = 2'd0;
    go       = 1'b1;
    ok       = 1'b0;
    c_term   = 1'b0;
    if (in_if.end_of_expr) begin
      if (!err_r) begin
        unique case (mode_r)
          qbt_pkg::MODE_BLOCK:
            qbt_pkg::put_res(step_rv, step_n, qbt_pkg::KIND_ERR, blk_open_r, '0,
                             qbt_pkg::ST_BLOCK_OPEN);
          qbt_pkg::MODE_STRING:
            qbt_pkg::put_res(step_rv, step_n, qbt_pkg::KIND_ERR, oq_r, '0,
                             qbt_pkg::ST_STRING_OPEN);
          qbt_pkg::MODE_CLOSED: begin
            ok = qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r,
                                    blk_close_r);
            if (ok) qbt_pkg::finish_tok(step_rv, step_n, cnt_nxt, '0);
          end
          qbt_pkg::MODE_NORMAL: begin
            if (esc_r) begin
              // dangling escape becomes text
              ok = qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r,
                                      esc_char_r);
              if (ok) qbt_pkg::finish_tok(step_rv, step_n, cnt_nxt, '0);
            end else begin
              qbt_pkg::finish_tok(step_rv, step_n, cnt_nxt, '0);
            end
          end
        endcase
      end
      mode_nxt = qbt_pkg::MODE_NORMAL;
      esc_nxt  = 1'b0;
      oq_nxt   = '0;
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
    end else if (!err_r) begin
      // the character after a closer decides how the block token ends
      if (mode_r == qbt_pkg::MODE_CLOSED) begin
        mode_nxt = qbt_pkg::MODE_NORMAL;
        if (c_dl) begin
          ok = qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r,
                                  blk_close_r);
          if (ok) qbt_pkg::finish_tok(step_rv, step_n, cnt_nxt, c);
          go = 1'b0;
        end else begin
          qbt_pkg::finish_tok(step_rv, step_n, cnt_nxt, blk_close_r);
        end
      end
      if (go && esc_nxt) begin
        esc_nxt = 1'b0;
        if (mode_nxt == qbt_pkg::MODE_STRING)      c_term = (c == oq_nxt);
        else if (mode_nxt == qbt_pkg::MODE_BLOCK)  c_term = (c == blk_close_r);
        else                                       c_term = c_dl;
        if (c_term) begin
          // escaped terminator is plain text
          void'(qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r, c));
          go = 1'b0;
        end else begin
          ok = qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r,
                                  esc_char_r);
          if (!ok) go = 1'b0;
        end
      end
      if (go) begin
        unique case (mode_nxt)
          qbt_pkg::MODE_NORMAL: begin
            if (c_dl) begin
              if ((c != '0) && ((c == quote_a_r) || (c == quote_b_r))) begin
                // drop a leading quote
                ok = 1'b1;
                if (cnt_nxt != '0) begin
                  ok = qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r, c);
                end
                if (ok) begin
                  oq_nxt   = c;
                  mode_nxt = qbt_pkg::MODE_STRING;
                end
              end else if ((blk_open_r != '0) && (c == blk_open_r)) begin
                ok = qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r, c);
                if (ok) mode_nxt = qbt_pkg::MODE_BLOCK;
              end else begin
                qbt_pkg::finish_tok(step_rv, step_n, cnt_nxt, c);
              end
            end else if (c_esc) begin
              esc_nxt = 1'b1;
            end else begin
              void'(qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r, c));
            end
          end
          qbt_pkg::MODE_STRING: begin
            if (c == oq_nxt) begin
              qbt_pkg::finish_tok(step_rv, step_n, cnt_nxt, c);
              mode_nxt = qbt_pkg::MODE_NORMAL;
              oq_nxt   = '0;
            end else if (c_esc) begin
              esc_nxt = 1'b1;
            end else begin
              void'(qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r, c));
            end
          end
          qbt_pkg::MODE_BLOCK, qbt_pkg::MODE_CLOSED: begin
            if (c == blk_close_r) begin
              mode_nxt = qbt_pkg::MODE_CLOSED;
            end else if (c_esc) begin
              esc_nxt = 1'b1;
            end else begin
              void'(qbt_pkg::text_char(step_rv, step_n, cnt_nxt, err_nxt, max_len_r, c));
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= qbt_pkg::MODE_NORMAL;
      esc_r     <= 1'b0;
      oq_r      <= '0;
      cnt_r     <= '0;
      err_r     <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r    <= mode_nxt;
        esc_r     <= esc_nxt;
        oq_r      <= oq_nxt;
        cnt_r     <= cnt_nxt;
        err_r     <= err_nxt;
        res_cnt_r <= step_n;
      end else if (out_fire) begin
        res_cnt_r <= res_cnt_r - 2'd1;
      end
    end
  end

  // payload: load a new group, or shift one beat out
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r <= step_rv;
    end else if (out_fire) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  assign out_if.valid        = (res_cnt_r != 2'd0);
  assign out_if.kind         = slot_r[0].kind;
  assign out_if.value        = slot_r[0].value;
  assign out_if.token_length = slot_r[0].token_length;
  assign out_if.status       = slot_r[0].status;
  assign out_if.last         = (res_cnt_r == 2'd1);

  `QBT_ASSERT_NEXT(a_end_resets, in_fire && in_if.end_of_expr,
    mode_r == qbt_pkg::MODE_NORMAL && cnt_r == '0 && !err_r && !esc_r)
  `QBT_ASSERT_NOW(a_err_silent, in_fire && err_r && !in_if.end_of_expr,
    step_n == 2'd0)
  `QBT_ASSERT_NOW(a_closed_no_esc, mode_r == qbt_pkg::MODE_CLOSED, !esc_r)
  `QBT_ASSERT_NOW(a_status_on_err, out_if.valid && slot_r[0].kind != qbt_pkg::KIND_ERR,
    slot_r[0].status == qbt_pkg::ST_OK)

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for quoted_block_tokenizer: drives character beats, predicts every result
// beat with a behavioral tokenizer and compares them in order. Needs qbt_pkg, qbt_in_if,
// qbt_out_if and the tokenizer RTL.
`timescale 1ns / 1ps

module tb;

  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 6;
  localparam int PhaseItems  = 30;

  typedef struct packed {
    qbt_pkg::kind_t   kind;
    logic [7:0]       value;
    logic [12:0]      length;
    qbt_pkg::status_t status;
    logic             last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [qbt_pkg::CfgIdxW-1:0] cfg_index;
  logic [qbt_pkg::CfgW-1:0] cfg_wdata;

  qbt_in_if  in_ch ();
  qbt_out_if out_ch ();

  quoted_block_tokenizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies
  logic [63:0] dmap_lo, dmap_hi;
  logic [7:0]  esc_c, quote_a, quote_b, blk_open, blk_close;
  logic [12:0] len_limit;
  // scan state
  qbt_pkg::mode_t cur_mode;
  logic        esc_held;
  logic [7:0]  quote_open;
  logic [12:0] tok_len;
  logic        err_hold;

  beat_t      step_out[$];
  beat_t      expected_beats[$];
  logic [7:0] delim_codes[$];
  int         mismatches = 0;
  int         sent_items = 0;
  bit         idling;
  bit         hold_req;
  int         hold_cnt = 0;
  int         stall_cnt = 0;

  function automatic void tokenizer_reset();
    dmap_lo = '0; dmap_hi = '0;
    esc_c = qbt_pkg::EscapeRst; quote_a = qbt_pkg::QuoteARst; quote_b = qbt_pkg::QuoteBRst;
    blk_open = qbt_pkg::BlkOpenRst; blk_close = qbt_pkg::BlkCloseRst;
    len_limit = qbt_pkg::MaxLenRst;
    cur_mode = qbt_pkg::MODE_NORMAL; esc_held = 1'b0; quote_open = '0;
    tok_len = '0; err_hold = 1'b0;
  endfunction

  function automatic void push_beat(qbt_pkg::kind_t k, logic [7:0] v, logic [12:0] l,
                                    qbt_pkg::status_t s);
    beat_t b;
    if (step_out.size() < qbt_pkg::MaxRes) begin
      b.kind = k; b.value = v; b.length = l; b.status = s; b.last = 1'b0;
      step_out.push_back(b);
    end
  endfunction

  function automatic bit is_delim_char(logic [7:0] c);
    if (c < 8'd64) return dmap_lo[c[5:0]];
    if (c < 8'd128) return dmap_hi[c[5:0]];
    return 1'b0;
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    return esc_c != 8'd0 && c == esc_c;
  endfunction

  // Append one character to the token, or latch the length error.
  function automatic bit take_char(logic [7:0] c);
    if ({1'b0, tok_len} + 14'd1 >= {1'b0, len_limit}) begin
      push_beat(qbt_pkg::KIND_ERR, 8'd0, 13'd0, qbt_pkg::ST_TOO_LONG);
      err_hold = 1'b1;
      return 1'b0;
    end
    tok_len = tok_len + 13'd1;
    push_beat(qbt_pkg::KIND_CHAR, c, 13'd0, qbt_pkg::ST_OK);
    return 1'b1;
  endfunction

  function automatic void close_token(logic [7:0] d);
    push_beat(qbt_pkg::KIND_END, d, tok_len, qbt_pkg::ST_OK);
    tok_len = '0;
  endfunction

  function automatic bit ends_here(logic [7:0] c);
    if (cur_mode == qbt_pkg::MODE_STRING) return c == quote_open;
    if (cur_mode == qbt_pkg::MODE_BLOCK) return c == blk_close;
    return is_delim_char(c);
  endfunction

  function automatic void advance_char(logic [7:0] c);
    case (cur_mode)
      qbt_pkg::MODE_NORMAL: begin
        if (is_delim_char(c)) begin
          if (c != 8'd0 && (c == quote_a || c == quote_b)) begin
            // a quote opening an empty token is dropped
            if (tok_len != 13'd0) begin
              if (!take_char(c)) return;
            end
            quote_open = c;
            cur_mode = qbt_pkg::MODE_STRING;
          end else if (blk_open != 8'd0 && c == blk_open) begin
            if (take_char(c)) cur_mode = qbt_pkg::MODE_BLOCK;
          end else begin
            close_token(c);
          end
        end else if (is_escape_char(c)) begin
          esc_held = 1'b1;
        end else begin
          void'(take_char(c));
        end
      end
      qbt_pkg::MODE_STRING: begin
        if (c == quote_open) begin
          close_token(c);
          cur_mode = qbt_pkg::MODE_NORMAL;
          quote_open = '0;
        end else if (is_escape_char(c)) begin
          esc_held = 1'b1;
        end else begin
          void'(take_char(c));
        end
      end
      default: begin
        if (c == blk_close) cur_mode = qbt_pkg::MODE_CLOSED;
        else if (is_escape_char(c)) esc_held = 1'b1;
        else void'(take_char(c));
      end
    endcase
  endfunction

  // Work out the result beats of one accepted input beat.
  function automatic void tokenize_step(logic [7:0] c, logic eoe);
    bit go;
    step_out.delete();
    if (eoe) begin
      if (!err_hold) begin
        case (cur_mode)
          qbt_pkg::MODE_BLOCK:
            push_beat(qbt_pkg::KIND_ERR, blk_open, 13'd0, qbt_pkg::ST_BLOCK_OPEN);
          qbt_pkg::MODE_STRING:
            push_beat(qbt_pkg::KIND_ERR, quote_open, 13'd0, qbt_pkg::ST_STRING_OPEN);
          qbt_pkg::MODE_CLOSED: if (take_char(blk_close)) close_token(8'd0);
          default: begin
            if (esc_held) begin
              if (take_char(esc_c)) close_token(8'd0);
            end else begin
              close_token(8'd0);
            end
          end
        endcase
      end
      cur_mode = qbt_pkg::MODE_NORMAL; esc_held = 1'b0; quote_open = '0;
      tok_len = '0; err_hold = 1'b0;
    end else if (!err_hold) begin
      go = 1'b1;
      // the character after a closer decides how the block token ends
      if (cur_mode == qbt_pkg::MODE_CLOSED) begin
        cur_mode = qbt_pkg::MODE_NORMAL;
        if (is_delim_char(c)) begin
          if (take_char(blk_close)) close_token(c);
          go = 1'b0;
        end else begin
          close_token(blk_close);
        end
      end
      if (go && esc_held) begin
        esc_held = 1'b0;
        if (ends_here(c)) begin
          void'(take_char(c));
          go = 1'b0;
        end else if (!take_char(esc_c)) begin
          go = 1'b0;
        end
      end
      if (go) advance_char(c);
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[i]) expected_beats.push_back(step_out[i]);
  endfunction

  function automatic logic [127:0] with_delim(logic [127:0] m, logic [7:0] c);
    if (c < 8'd128) m[c[6:0]] = 1'b1;
    return m;
  endfunction

  function automatic logic [127:0] delim_set(string s);
    logic [127:0] m;
    m = '0;
    foreach (s[i]) m = with_delim(m, s[i]);
    return m;
  endfunction

  function automatic logic [7:0] pick_delim();
    if (delim_codes.size() == 0) return 8'($urandom_range(0, 255));
    return delim_codes[$urandom_range(0, delim_codes.size() - 1)];
  endfunction

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldCycles - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_cnt != 0) begin
      out_ch.ready <= 1'b0;
      stall_cnt = stall_cnt - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_cnt = $urandom_range(0, 16);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Predict on each input beat, then check each result beat against the oldest prediction.
  always @(posedge clk) begin : monitor
    beat_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sent_items++;
        tokenize_step(in_ch.char_in, in_ch.end_of_expr);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.value, out_ch.token_length, out_ch.status, out_ch.last};
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("tb: unexpected beat at %0t: kind=%0d value=%0d len=%0d status=%0d last=%0d",
                     $time, got.kind, got.value, got.length, got.status, got.last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.length !== want.length || got.status !== want.status ||
              got.last !== want.last) begin
            if (mismatches < 10)
              $display({"tb: beat mismatch at %0t: want kind=%0d value=%0d len=%0d ",
                        "status=%0d last=%0d, got kind=%0d value=%0d len=%0d status=%0d last=%0d"},
                       $time, want.kind, want.value, want.length, want.status, want.last,
                       got.kind, got.value, got.length, got.status, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic eoe);
    if (idling && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.char_in     <= c;
    in_ch.end_of_expr <= eoe;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i], 1'b0);
  endtask

  task automatic send_word(int n);
    repeat (n) send_char(word_char(), 1'b0);
  endtask

  task automatic end_expr();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(qbt_pkg::cfg_idx_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      qbt_pkg::REG_DELIM_LO:  dmap_lo = data;
      qbt_pkg::REG_DELIM_HI:  dmap_hi = data;
      qbt_pkg::REG_ESCAPE:    esc_c = data[7:0];
      qbt_pkg::REG_QUOTE_A:   quote_a = data[7:0];
      qbt_pkg::REG_QUOTE_B:   quote_b = data[7:0];
      qbt_pkg::REG_BLK_OPEN:  blk_open = data[7:0];
      qbt_pkg::REG_BLK_CLOSE: blk_close = data[7:0];
      default:                len_limit = data[12:0];
    endcase
  endtask

  task automatic set_config(input logic [127:0] dmap, input logic [7:0] e, qa, qb, bo, bc,
                            input logic [12:0] ml);
    drain();
    write_reg(qbt_pkg::REG_DELIM_LO, dmap[63:0]);
    write_reg(qbt_pkg::REG_DELIM_HI, dmap[127:64]);
    write_reg(qbt_pkg::REG_ESCAPE, 64'(e));
    write_reg(qbt_pkg::REG_QUOTE_A, 64'(qa));
    write_reg(qbt_pkg::REG_QUOTE_B, 64'(qb));
    write_reg(qbt_pkg::REG_BLK_OPEN, 64'(bo));
    write_reg(qbt_pkg::REG_BLK_CLOSE, 64'(bc));
    write_reg(qbt_pkg::REG_MAX_LEN, 64'(ml));
    @(negedge clk);
    cfg_we <= 1'b0;
    delim_codes.delete();
    for (int c = 0; c < 128; c++) if (dmap[c]) delim_codes.push_back(8'(c));
  endtask

  task automatic send_expression();
    logic [7:0] q;
    logic [7:0] cand[4];
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_word($urandom_range(1, 5));
        3: send_char(pick_delim(), 1'b0);
        4: begin
          q = $urandom_range(0, 1) ? quote_a : quote_b;
          send_char(q, 1'b0);
          send_word($urandom_range(0, 4));
          if ($urandom_range(0, 1)) begin
            send_char(esc_c, 1'b0);
            send_char(q, 1'b0);
            send_word($urandom_range(0, 2));
          end
          if ($urandom_range(0, 7) != 0) send_char(q, 1'b0);
        end
        5, 6: begin
          send_char(blk_open, 1'b0);
          send_word($urandom_range(0, 4));
          if ($urandom_range(0, 2) == 0) begin
            send_char(esc_c, 1'b0);
            send_char(blk_close, 1'b0);
          end
          if ($urandom_range(0, 7) != 0) send_char(blk_close, 1'b0);
        end
        7: begin
          cand = '{pick_delim(), blk_close, quote_a, word_char()};
          send_char(esc_c, 1'b0);
          send_char(cand[$urandom_range(0, 3)], 1'b0);
        end
        default: send_char(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    end_expr();
  endtask

  task automatic test_reset_defaults();
    // no delimiters after reset: a quote is plain text
    send_text("a\"");
    end_expr();
  endtask

  task automatic test_token_rules();
    set_config(delim_set(" ,;\"'{"), qbt_pkg::EscapeRst, qbt_pkg::QuoteARst,
               qbt_pkg::QuoteBRst, qbt_pkg::BlkOpenRst, qbt_pkg::BlkCloseRst,
               qbt_pkg::MaxLenRst);
    send_text("a\\,b ");
    send_text("\"x\\\"\"");
    // closer then plain text, closer then delimiter
    send_text("{}b{},");
    send_text("q'");
    end_expr();
    send_text("{}");
    end_expr();
    send_text("\\");
    end_expr();
    send_text("{");
    end_expr();
  endtask

  task automatic test_too_long();
    set_config(delim_set(" ,;\"'{"), qbt_pkg::EscapeRst, qbt_pkg::QuoteARst,
               qbt_pkg::QuoteBRst, qbt_pkg::BlkOpenRst, qbt_pkg::BlkCloseRst, 13'd3);
    // third character overflows, the rest of the expression is dropped
    send_text("abcd");
    end_expr();
  endtask

  task automatic test_backpressure();
    idling = 1'b0;
    set_config(delim_set(" ,"), qbt_pkg::EscapeRst, qbt_pkg::QuoteARst, qbt_pkg::QuoteBRst,
               qbt_pkg::BlkOpenRst, qbt_pkg::BlkCloseRst, 13'd4096);
    hold_req = 1'b1;
    repeat (6) begin
      send_word(5);
      send_char(" ", 1'b0);
    end
    end_expr();
    drain();
    idling = 1'b1;
  endtask

  task automatic test_pause_mid_token();
    send_text("ab");
    drain();
    send_text("c{d");
    drain();
    send_text("} ");
    end_expr();
  endtask

  task automatic test_random_streams();
    logic [127:0] m;
    logic [7:0]   e, qa, qb, bo, bc;
    logic [12:0]  ml;
    int           goal;
    for (int p = 0; p < 7; p++) begin
      idling = (p < 5);
      e = pick_code(); qa = pick_code(); qb = pick_code();
      bo = pick_code(); bc = pick_code();
      ml = ($urandom_range(0, 3) == 0) ? 13'd256 : 13'($urandom_range(2, 14));
      m = {$urandom, $urandom, $urandom, $urandom} & {$urandom, $urandom, $urandom, $urandom}
          & {$urandom, $urandom, $urandom, $urandom};
      m = with_delim(with_delim(with_delim(m | delim_set(" ,;"), qa), qb), bo);
      case (p)
        0: begin
          m  = '1;
          ml = 13'd4096;
        end
        1: begin
          m = '0; e = 8'd0; qa = 8'd0; qb = 8'd0; bo = 8'd0;
          ml = 13'd1;
        end
        2: begin
          ml = 13'd0; e = 8'd255; bc = 8'd255;
        end
        3: begin
          // opener equal to a quote: the quote takes precedence
          qa = 8'd0;
          bo = qb;
        end
        default: ;
      endcase
      set_config(m, e, qa, qb, bo, bc, ml);
      goal = sent_items + PhaseItems;
      while (sent_items < goal) send_expression();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.char_in = '0;
    in_ch.end_of_expr = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = qbt_pkg::REG_DELIM_LO;
    cfg_wdata = '0;
    rst_n = 1'b0;
    idling = 1'b1;
    hold_req = 1'b0;
    tokenizer_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_token_rules();
    test_too_long();
    test_backpressure();
    test_pause_mid_token();
    test_random_streams();
    drain();

    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
